// ===== rtl/core/aarm_pkg.sv =====
// Package: constants, types and CORDIC arctangent table for the angle-to-matrix block.
package aarm_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int PHASE_W  = 32;
    localparam int CW       = 34;
    localparam int AXIS_W   = 16;
    localparam int ENTRY_W  = 16;
    localparam int NUM_REGS = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 2'd2;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [PHASE_W-1:0] PHASE_EIGHTH = 32'h2000_0000;

    typedef logic signed [CW-1:0] cval_t;

    function automatic logic [PHASE_W-1:0] atan_turns(input int i);
        logic [PHASE_W-1:0] t;
        case (i)
            0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;  11: t = 32'h000517CC;
            12: t = 32'h00028BE6;  13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
            16: t = 32'h000028BE;  17: t = 32'h0000145F;
            18: t = 32'h00000A30;  19: t = 32'h00000518;
            20: t = 32'h0000028C;  21: t = 32'h00000146;
            22: t = 32'h000000A3;  23: t = 32'h00000051;
            24: t = 32'h00000029;  25: t = 32'h00000014;
            26: t = 32'h0000000A;  27: t = 32'h00000005;
            28: t = 32'h00000003;  29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/axis_angle_to_rotation_matrix_top.sv =====
// Top level: joint angle to 3x3 rotation matrix about the configured axis.
// Throughput: one word per cycle; a pipelined CORDIC, one stage per iteration,
// then registered quadrant, product, sum and rounding stages. The whole pipe advances on !stall.
// Reset: axis registers go to (1,0,0), all valid bits clear; no clearing pass.
module axis_angle_to_rotation_matrix_top #(
    parameter int ANGLE_BITS    = aarm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // joint_angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

    localparam int CW  = aarm_pkg::CW;
    localparam int PW  = aarm_pkg::PHASE_W;
    localparam int NS  = CORDIC_STAGES;
    localparam int KKW = 2 * aarm_pkg::AXIS_W + 2;
    localparam int PRW = CW + KKW;
    localparam int ACW = PRW + 2;

    logic signed [15:0] ax_reg, ay_reg, az_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg <= 16'sd16384;
            ay_reg <= '0;
            az_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                aarm_pkg::REG_AXIS_X: ax_reg <= cfg_data;
                aarm_pkg::REG_AXIS_Y: ay_reg <= cfg_data;
                aarm_pkg::REG_AXIS_Z: az_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // K and K^2 (config-static, K^2 registered)
    logic signed [KKW-1:0] k_m [9];
    logic signed [KKW-1:0] kk_next [9];
    logic signed [KKW-1:0] kk_reg [9];
    logic signed [KKW-1:0] kx, ky, kz;
    logic signed [KKW-1:0] hf;

    always_comb begin
        kx = KKW'(ax_reg);
        ky = KKW'(ay_reg);
        kz = KKW'(az_reg);
        hf = KKW'(1) <<< (FRAC_BITS - 1);
        k_m[0] = '0;  k_m[1] = -kz; k_m[2] = ky;
        k_m[3] = kz;  k_m[4] = '0;  k_m[5] = -kx;
        k_m[6] = -ky; k_m[7] = kx;  k_m[8] = '0;
        kk_next[0] = (-(kz*kz) - ky*ky + hf) >>> FRAC_BITS;
        kk_next[1] = (ky*kx + hf) >>> FRAC_BITS;
        kk_next[2] = (kz*kx + hf) >>> FRAC_BITS;
        kk_next[3] = (kx*ky + hf) >>> FRAC_BITS;
        kk_next[4] = (-(kz*kz) - kx*kx + hf) >>> FRAC_BITS;
        kk_next[5] = (kz*ky + hf) >>> FRAC_BITS;
        kk_next[6] = (kx*kz + hf) >>> FRAC_BITS;
        kk_next[7] = (ky*kz + hf) >>> FRAC_BITS;
        kk_next[8] = (-(ky*ky) - kx*kx + hf) >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 9; i++) kk_reg[i] <= kk_next[i];
    end

    // total pipeline: stage 0 phase, NS cordic, quad, products, sum, finish
    localparam int NP = NS + 5;
    logic stall;
    logic vld_reg [NP];

    assign stall    = m_tvalid && !m_tready;
    assign s_tready = !stall;
    assign m_tvalid = vld_reg[NP-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) vld_reg[i] <= 1'b0;
        end else if (!stall) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NP; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // phase stage
    logic [PW-1:0] phase_next, shifted_next;
    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic signed [PW:0]   z_reg [NS+1];
    logic [1:0]           q_reg [NS+1];

    always_comb begin
        phase_next   = PW'($signed(s_tdata)) << (PW - ANGLE_BITS);
        shifted_next = phase_next + aarm_pkg::PHASE_EIGHTH;
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            x_reg[0] <= aarm_pkg::GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({3'b000, shifted_next[29:0]}) - $signed({1'b0, aarm_pkg::PHASE_EIGHTH});
            q_reg[0] <= shifted_next[31:30];
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        localparam logic [PW-1:0] AT = aarm_pkg::atan_turns(g);
        always_ff @(posedge aclk) begin
            if (!stall) begin
                if (!z_reg[g][PW]) begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - $signed({1'b0, AT});
                end else begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + $signed({1'b0, AT});
                end
                q_reg[g+1] <= q_reg[g];
            end
        end
    end

    // quadrant stage
    logic signed [CW-1:0] sn_reg, omc_reg;
    logic signed [CW-1:0] cs_c, sn_c;

    always_comb begin
        case (q_reg[NS])
            2'd0:    begin cs_c = x_reg[NS];  sn_c = y_reg[NS];  end
            2'd1:    begin cs_c = -y_reg[NS]; sn_c = x_reg[NS];  end
            2'd2:    begin cs_c = -x_reg[NS]; sn_c = -y_reg[NS]; end
            default: begin cs_c = y_reg[NS];  sn_c = -x_reg[NS]; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            sn_reg  <= sn_c;
            omc_reg <= (CW'(1) <<< 30) - cs_c;
        end
    end

    // products, sum, finish
    logic signed [PRW-1:0] ps_reg [9];
    logic signed [PRW-1:0] po_reg [9];
    logic signed [ACW-1:0] acc_reg [9];
    logic signed [15:0]    e_reg [9];

    for (genvar e = 0; e < 9; e++) begin : g_ent
        logic signed [ACW-1:0] rnd;
        logic signed [ACW-1:0] one_f;
        always_comb begin
            one_f = ACW'(1) <<< FRAC_BITS;
            rnd   = (acc_reg[e] + (ACW'(1) <<< 29)) >>> 30;
        end
        always_ff @(posedge aclk) begin
            if (!stall) begin
                ps_reg[e]  <= PRW'(sn_reg) * PRW'(k_m[e]);
                po_reg[e]  <= PRW'(omc_reg) * PRW'(kk_reg[e]);
                acc_reg[e] <= ACW'(ps_reg[e]) + ACW'(po_reg[e])
                              + ((e % 4 == 0) ? (ACW'(1) <<< (30 + FRAC_BITS)) : ACW'(0));
                if (rnd > one_f)
                    e_reg[e] <= (one_f > ACW'(32767)) ? 16'sh7fff : 16'(one_f);
                else if (rnd < -one_f)
                    e_reg[e] <= (-one_f < -ACW'(32768)) ? 16'sh8000 : 16'(-one_f);
                else if (rnd > ACW'(32767))
                    e_reg[e] <= 16'sh7fff;
                else if (rnd < -ACW'(32768))
                    e_reg[e] <= 16'sh8000;
                else
                    e_reg[e] <= 16'(rnd);
            end
        end
        assign m_tdata[16*e +: 16] = e_reg[e];
    end

endmodule
